// ===== rtl/core/keyboard_serial_transmitter_macros.svh =====
// Assertion macros for the keyboard serial transmitter.
// Used by the top level only; relies on a clock named clock and a reset named reset.
`ifndef KEYBOARD_SERIAL_TRANSMITTER_MACROS_SVH
`define KEYBOARD_SERIAL_TRANSMITTER_MACROS_SVH

// Property checked at every rising edge, ignored while reset is high.
`define KST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define KST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/kbdtx_pkg.sv =====
// Package of the keyboard serial transmitter: payload structs, phase codes,
// configuration layout and the phase duration function. No dependencies.
package kbdtx_pkg;

   localparam int unsigned TimerWidth = 20;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth = 20;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CSR_PULSE_TICKS = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PHASE_TICKS = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_FIRST_WINDOW = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RETRY_WINDOW = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_RETRY_LIMIT = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_RESET_HOLD = 3'd5;

   // Commands of a request.
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_SEND = 2'd1;
   localparam logic [1:0] CMD_HANDSHAKE = 2'd2;
   localparam logic [1:0] CMD_FORCE_RESET = 2'd3;

   // Key code that is never sent.
   localparam logic [7:0] KEY_IGNORED = 8'hFF;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_BIT_PRE    = 4'd1,
      PH_BIT_LOW    = 4'd2,
      PH_BIT_POST   = 4'd3,
      PH_HS_PULSE   = 4'd4,
      PH_HS_GAP     = 4'd5,
      PH_WAIT_FIRST = 4'd6,
      PH_RT_PRE     = 4'd7,
      PH_RT_LOW     = 4'd8,
      PH_RT_POST    = 4'd9,
      PH_RT_GAP     = 4'd10,
      PH_WAIT_RETRY = 4'd11,
      PH_RESET_HOLD = 4'd12
   } phase_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] key_byte;
      logic       data_line_in;
   } req_type;

   typedef struct packed {
      logic clock_drive_low;
      logic data_drive_low;
      logic reset_drive_low;
      logic busy_res;
      logic sync_done;
      logic sync_failed;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  pulse_ticks;
      logic [7:0]  phase_ticks;
      logic [9:0]  first_window_ticks;
      logic [9:0]  retry_window_ticks;
      logic [7:0]  retry_limit;
      logic [19:0] reset_hold_ticks;
   } cfg_type;

   // Length of a phase in ticks; a zero register counts as one tick.
   function automatic logic [TimerWidth-1:0] phase_duration(phase_type ph, cfg_type cfg);
      logic [TimerWidth-1:0] d;
      case (ph)
         PH_IDLE:       d = '0;
         PH_HS_PULSE:   d = TimerWidth'(cfg.pulse_ticks);
         PH_WAIT_FIRST: d = TimerWidth'(cfg.first_window_ticks);
         PH_WAIT_RETRY: d = TimerWidth'(cfg.retry_window_ticks);
         PH_RESET_HOLD: d = cfg.reset_hold_ticks;
         default:       d = TimerWidth'(cfg.phase_ticks);
      endcase
      if (ph != PH_IDLE && d == '0) begin
         d = TimerWidth'(1);
      end
      return d;
   endfunction

endpackage

// ===== rtl/core/keyboard_serial_transmitter.sv =====
// Top level of the keyboard serial transmitter: phase sequencer and result queue.
// Depends on kbdtx_pkg and keyboard_serial_transmitter_macros.svh.
//
// Usage: every request is one microsecond tick. It carries a command, a key byte
// and the sampled data line; each request yields exactly one result with the line
// drives and status flags for that tick. A send serialises bits 6 down to 0 and
// then bit 7, each bit as pre, low and post phases, then the handshake pulse, the
// acknowledge window and any retries. A handshake command runs the handshake alone,
// a force reset holds the clock and reset lines low. Commands are taken only when
// the block is idle; key code 0xFF is ignored.
// Throughput is one request per cycle while the queue has room: the sequencer
// state is updated by a single pass of logic at the accepting edge, its critical
// path being the 20-bit tick timer decrement and zero test. The result of a request
// is registered at its acceptance and offered on rsp once earlier results are taken.
// A two-entry result queue lies between the sides, so one further request is taken
// while a result waits; with two results held, req_ready drops until rsp_ready.
// Reset (synchronous) empties the queue, sets the sequencer idle and loads the
// register defaults. Configuration writes are always accepted (csr_ready high).
`include "keyboard_serial_transmitter_macros.svh"

module keyboard_serial_transmitter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  kbdtx_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output kbdtx_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [kbdtx_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [kbdtx_pkg::CsrDataWidth-1:0]     csr_data
);

   kbdtx_pkg::cfg_type cfg_ff, cfg_in;

   kbdtx_pkg::phase_type             phase_ff, phase_in;
   logic [kbdtx_pkg::TimerWidth-1:0] timer_ff, timer_in;
   logic [7:0]                       shift_ff, shift_in;
   logic [3:0]                       bit_count_ff, bit_count_in;
   logic [7:0]                       retry_count_ff, retry_count_in;
   logic                             ack_ff, ack_in;

   kbdtx_pkg::rsp_type result;

   kbdtx_pkg::rsp_type head_ff, head_in;
   kbdtx_pkg::rsp_type tail_ff, tail_in;
   logic [1:0]         count_ff, count_in;

   logic req_fire;
   logic rsp_fire;

   assign csr_ready = 1'b1;
   assign req_ready = (count_ff != 2'd2);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_data  = head_ff;

   // Configuration register writes, truncated to each register's width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            kbdtx_pkg::CSR_PULSE_TICKS:  cfg_in.pulse_ticks = csr_data[7:0];
            kbdtx_pkg::CSR_PHASE_TICKS:  cfg_in.phase_ticks = csr_data[7:0];
            kbdtx_pkg::CSR_FIRST_WINDOW: cfg_in.first_window_ticks = csr_data[9:0];
            kbdtx_pkg::CSR_RETRY_WINDOW: cfg_in.retry_window_ticks = csr_data[9:0];
            kbdtx_pkg::CSR_RETRY_LIMIT:  cfg_in.retry_limit = csr_data[7:0];
            kbdtx_pkg::CSR_RESET_HOLD:   cfg_in.reset_hold_ticks = csr_data[19:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks        <= 8'd1;
         cfg_ff.phase_ticks        <= 8'd20;
         cfg_ff.first_window_ticks <= 10'd170;
         cfg_ff.retry_window_ticks <= 10'd120;
         cfg_ff.retry_limit        <= 8'd255;
         cfg_ff.reset_hold_ticks   <= 20'd600000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Phase sequencer: next state and the result of the current tick.
   always_comb begin
      kbdtx_pkg::phase_type             ph;
      logic [kbdtx_pkg::TimerWidth-1:0] tmr;
      logic [2:0]                       bit_idx;

      ph             = phase_ff;
      tmr            = timer_ff;
      shift_in       = shift_ff;
      bit_count_in   = bit_count_ff;
      retry_count_in = retry_count_ff;
      ack_in         = ack_ff;
      result         = '0;

      // A command is taken only while idle and starts in the same tick.
      if (ph == kbdtx_pkg::PH_IDLE) begin
         if (req_data.cmd == kbdtx_pkg::CMD_SEND &&
             req_data.key_byte != kbdtx_pkg::KEY_IGNORED) begin
            shift_in     = req_data.key_byte;
            bit_count_in = 4'd0;
            ph           = kbdtx_pkg::PH_BIT_PRE;
         end else if (req_data.cmd == kbdtx_pkg::CMD_HANDSHAKE) begin
            ack_in         = 1'b0;
            retry_count_in = 8'd0;
            ph             = kbdtx_pkg::PH_HS_PULSE;
         end else if (req_data.cmd == kbdtx_pkg::CMD_FORCE_RESET) begin
            ph = kbdtx_pkg::PH_RESET_HOLD;
         end
         tmr = kbdtx_pkg::phase_duration(ph, cfg_ff);
      end

      // Line drives for this tick.
      bit_idx = (bit_count_in < 4'd7) ? 3'(4'd6 - bit_count_in) : 3'd7;
      result.busy_res = (ph != kbdtx_pkg::PH_IDLE);
      if (ph inside {kbdtx_pkg::PH_BIT_PRE, kbdtx_pkg::PH_BIT_LOW,
                     kbdtx_pkg::PH_BIT_POST}) begin
         result.data_drive_low = shift_in[bit_idx];
      end
      if (ph inside {kbdtx_pkg::PH_HS_PULSE, kbdtx_pkg::PH_RT_PRE, kbdtx_pkg::PH_RT_LOW,
                     kbdtx_pkg::PH_RT_POST}) begin
         result.data_drive_low = 1'b1;
      end
      if (ph inside {kbdtx_pkg::PH_BIT_LOW, kbdtx_pkg::PH_RT_LOW,
                     kbdtx_pkg::PH_RESET_HOLD}) begin
         result.clock_drive_low = 1'b1;
      end
      result.reset_drive_low = (ph == kbdtx_pkg::PH_RESET_HOLD);

      // Acknowledge is sampled only inside the windows.
      if ((ph == kbdtx_pkg::PH_WAIT_FIRST || ph == kbdtx_pkg::PH_WAIT_RETRY) &&
          !req_data.data_line_in) begin
         ack_in = 1'b1;
      end

      // Count down the phase and move on when it runs out.
      phase_in = ph;
      timer_in = tmr;
      if (ph != kbdtx_pkg::PH_IDLE) begin
         timer_in = tmr - kbdtx_pkg::TimerWidth'(1);
         if (timer_in == '0) begin
            case (ph)
               kbdtx_pkg::PH_BIT_PRE:  phase_in = kbdtx_pkg::PH_BIT_LOW;
               kbdtx_pkg::PH_BIT_LOW:  phase_in = kbdtx_pkg::PH_BIT_POST;
               kbdtx_pkg::PH_BIT_POST: begin
                  bit_count_in = bit_count_in + 4'd1;
                  if (bit_count_in >= 4'd8) begin
                     ack_in         = 1'b0;
                     retry_count_in = 8'd0;
                     phase_in       = kbdtx_pkg::PH_HS_PULSE;
                  end else begin
                     phase_in = kbdtx_pkg::PH_BIT_PRE;
                  end
               end
               kbdtx_pkg::PH_HS_PULSE: phase_in = kbdtx_pkg::PH_HS_GAP;
               kbdtx_pkg::PH_HS_GAP:   phase_in = kbdtx_pkg::PH_WAIT_FIRST;
               kbdtx_pkg::PH_RT_PRE:   phase_in = kbdtx_pkg::PH_RT_LOW;
               kbdtx_pkg::PH_RT_LOW:   phase_in = kbdtx_pkg::PH_RT_POST;
               kbdtx_pkg::PH_RT_POST:  phase_in = kbdtx_pkg::PH_RT_GAP;
               kbdtx_pkg::PH_RT_GAP: begin
                  ack_in   = 1'b0;
                  phase_in = kbdtx_pkg::PH_WAIT_RETRY;
               end
               kbdtx_pkg::PH_WAIT_FIRST, kbdtx_pkg::PH_WAIT_RETRY: begin
                  if (ack_in) begin
                     result.sync_done = 1'b1;
                     phase_in         = kbdtx_pkg::PH_IDLE;
                  end else if (retry_count_in < cfg_ff.retry_limit) begin
                     retry_count_in = retry_count_in + 8'd1;
                     ack_in         = 1'b0;
                     phase_in       = kbdtx_pkg::PH_RT_PRE;
                  end else begin
                     result.sync_failed = 1'b1;
                     phase_in           = kbdtx_pkg::PH_IDLE;
                  end
               end
               default: phase_in = kbdtx_pkg::PH_IDLE;
            endcase
            timer_in = kbdtx_pkg::phase_duration(phase_in, cfg_ff);
         end
      end
   end

   // Sequencer registers advance only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= kbdtx_pkg::PH_IDLE;
         timer_ff       <= '0;
         shift_ff       <= '0;
         bit_count_ff   <= '0;
         retry_count_ff <= '0;
         ack_ff         <= 1'b0;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         timer_ff       <= timer_in;
         shift_ff       <= shift_in;
         bit_count_ff   <= bit_count_in;
         retry_count_ff <= retry_count_in;
         ack_ff         <= ack_in;
      end
   end

   // Two-entry result queue; the head is what the rsp channel shows.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
      if (req_fire && (count_ff == 2'd0 || (count_ff == 2'd1 && rsp_fire))) begin
         head_in = result;
      end else if (rsp_fire && count_ff == 2'd2) begin
         head_in = tail_ff;
      end
      if (req_fire && count_ff == 2'd1 && !rsp_fire) begin
         tail_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   // Checks on the sequencer and the queue.
   `KST_ASSERT(a_busy_timer_live, phase_ff != kbdtx_pkg::PH_IDLE |-> timer_ff != '0,
      "busy phase with expired timer")
   `KST_ASSERT(a_fire_gives_result, req_fire |=> rsp_valid,
      "accepted request left no result")
   `KST_ASSERT(a_reset_drive,
      result.reset_drive_low |-> result.clock_drive_low && result.busy_res,
      "reset drive without clock drive")
   `KST_ASSERT_ALWAYS(a_done_fail_excl, !(result.sync_done && result.sync_failed),
      "done and failed together")

endmodule
